>>> rtl/sliding_window_packet_buffer_defines.svh
// assertion macros for the sliding window packet buffer checker
// expects clk and rst in the scope of the module that uses them
`ifndef SLIDING_WINDOW_PACKET_BUFFER_DEFINES_SVH
`define SLIDING_WINDOW_PACKET_BUFFER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWPB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SWPB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/swpb_pkg.sv
// shared types and codes for the sliding window packet buffer
// used by the front, exec, result queue, top level and checker
`default_nettype none

package swpb_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int REF_WIDTH_DEF  = 32;

  localparam int CMD_W    = 3;
  localparam int SEQ_W    = 32;
  localparam int PREF_W   = 32;
  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  // classified operations handed from front to exec
  localparam logic [2:0] OP_STORE     = 3'd0;
  localparam logic [2:0] OP_FETCH     = 3'd1;
  localparam logic [2:0] OP_FETCH_LOW = 3'd2;
  localparam logic [2:0] OP_SLIDE_CNT = 3'd3;
  localparam logic [2:0] OP_SLIDE_TO  = 3'd4;
  localparam logic [2:0] OP_BAD       = 3'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [SEQ_W-1:0]   seq;
    logic [PREF_W-1:0]  pref;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   found_size;
    logic [PREF_W-1:0]   found_ref;
    logic                window_closed;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/swpb_front.sv
// front end: accepts command words, classifies them, queues them for exec
// depends on swpb_pkg
`default_nettype none

module swpb_front import swpb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic [PREF_W-1:0]  payload_ref,
  input  logic [SIZE_W-1:0]  payload_size,
  input  logic [COUNT_W-1:0] slide_count,
  output logic               item_valid,
  output item_t              item,
  input  logic               item_take
);

  localparam logic [CMD_W-1:0] CMD_STORE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FETCH_LOW = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SLIDE_CNT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SLIDE_TO  = 3'd4;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [2:0] op_in;
  logic       accept;
  logic       take;

  always_comb begin
    case (cmd)
      CMD_STORE:     op_in = OP_STORE;
      CMD_FETCH:     op_in = OP_FETCH;
      CMD_FETCH_LOW: op_in = OP_FETCH_LOW;
      CMD_SLIDE_CNT: op_in = OP_SLIDE_CNT;
      CMD_SLIDE_TO:  op_in = OP_SLIDE_TO;
      default:       op_in = OP_BAD;
    endcase
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign accept     = push && !full;
  assign take       = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      if (accept && !take) begin
        count <= count + 2'd1;
      end else if (!accept && take) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= '{op: op_in, seq: seq_num, pref: payload_ref,
                     size: payload_size, count: slide_count};
    end
  end

endmodule

`default_nettype wire

>>> rtl/swpb_exec.sv
// back end: window state, slot valid bits, slot memory and command sequencer
// depends on swpb_pkg
`default_nettype none

module swpb_exec import swpb_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int REF_WIDTH  = REF_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] window_size,
  input  logic             item_valid,
  input  item_t            item,
  output logic             item_take,
  input  logic             res_room,
  output logic             res_push,
  output result_t          res
);

  localparam int RING = MAX_WINDOW + 1;
  localparam int SW   = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (SW > COUNT_W) ? SW : COUNT_W;
  localparam int KW   = (REF_WIDTH < PREF_W) ? REF_WIDTH : PREF_W;
  localparam int MW   = SIZE_W + REF_WIDTH;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACT   = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_SLIDE = 2'd3;

  logic [1:0]           state;
  logic [SW-1:0]        ws;
  logic [SEQ_W-1:0]     lowest;
  logic [SEQ_W-1:0]     next_seq;
  logic [SEQ_W-1:0]     top;
  logic [SW-1:0]        span;
  logic [SW-1:0]        low_slot;
  logic [RING-1:0]      valid;
  logic [CW-1:0]        cnt;

  logic                 is_store;
  logic [SEQ_W-1:0]     seq_r;
  logic [SIZE_W-1:0]    size_r;
  logic [REF_WIDTH-1:0] ref_r;
  logic [SW-1:0]        off_r;

  logic [MW-1:0]        mem [RING];
  logic [MW-1:0]        rd_data;

  logic [SW-1:0]        ws_cfg;
  logic [SEQ_W-1:0]     key;
  logic [SEQ_W-1:0]     off_full;
  logic                 store_ok;
  logic                 fetch_ok;
  logic                 slide_to_ok;
  logic                 closed_cur;
  logic [SW:0]          slot_sum;
  logic [SW:0]          ring_sz;
  logic [SW:0]          slot_wide;
  logic [SW-1:0]        slot;
  logic                 slot_busy;
  logic                 raise_next;
  logic [SW-1:0]        span_store;
  logic                 mem_we;
  logic                 mem_re;

  // saturate the written window size to 1..MAX_WINDOW
  assign ws_cfg = (window_size == '0) ? SW'(1) :
                  ((32'(window_size) > 32'(MAX_WINDOW)) ? SW'(MAX_WINDOW) : SW'(window_size));

  // range checks on the queue head against the current window
  assign key         = (item.op == OP_FETCH_LOW) ? lowest : item.seq;
  assign off_full    = key - lowest;
  assign store_ok    = (item.seq != '0) && (item.seq >= lowest) && (item.seq <= top);
  assign fetch_ok    = (key >= lowest) && (key <= next_seq);
  assign slide_to_ok = (item.seq > lowest) && (item.seq <= next_seq);
  assign closed_cur  = (span == ws);

  // ring slot of the latched offset
  assign slot_sum  = {1'b0, low_slot} + {1'b0, off_r};
  assign ring_sz   = {1'b0, ws} + {{SW{1'b0}}, 1'b1};
  assign slot_wide = (slot_sum >= ring_sz) ? (slot_sum - ring_sz) : slot_sum;
  assign slot      = slot_wide[SW-1:0];
  assign slot_busy = valid[slot];

  assign raise_next = (off_r >= span);
  assign span_store = off_r + SW'(1);

  assign mem_we = (state == S_ACT) && is_store && !slot_busy;
  assign mem_re = (state == S_ACT) && !is_store && slot_busy;

  always_comb begin
    item_take = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.window_closed = closed_cur;
    case (state)
      S_IDLE: begin
        if (item_valid && res_room && !cfg_we) begin
          item_take = 1'b1;
          case (item.op)
            OP_STORE: begin
              res_push   = !store_ok;
              res.status = ST_ERR;
            end
            OP_FETCH, OP_FETCH_LOW: begin
              res_push   = !fetch_ok;
              res.status = ST_MISS;
            end
            OP_SLIDE_CNT: res_push = 1'b0;
            OP_SLIDE_TO: begin
              res_push   = !slide_to_ok;
              res.status = ST_ERR;
            end
            default: begin
              res_push   = 1'b1;
              res.status = ST_ERR;
            end
          endcase
        end
      end
      S_ACT: begin
        if (is_store) begin
          res_push = 1'b1;
          if (slot_busy) begin
            res.status = ST_DUP;
          end else begin
            res.status        = ST_OK;
            res.window_closed = raise_next ? (span_store == ws) : closed_cur;
          end
        end else if (!slot_busy) begin
          res_push   = 1'b1;
          res.status = ST_MISS;
        end
      end
      S_READ: begin
        res_push       = 1'b1;
        res.status     = ST_OK;
        res.found_size = rd_data[MW-1 -: SIZE_W];
        res.found_ref  = PREF_W'(rd_data[KW-1:0]);
      end
      S_SLIDE: begin
        if (cnt == '0) begin
          res_push   = 1'b1;
          res.status = ST_OK;
        end else if (span == '0) begin
          res_push   = 1'b1;
          res.status = ST_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ws       <= SW'(MAX_WINDOW);
      lowest   <= 32'd1;
      next_seq <= 32'd1;
      top      <= 32'(MAX_WINDOW);
      span     <= '0;
      low_slot <= '0;
      valid    <= '0;
      cnt      <= '0;
      is_store <= 1'b0;
    end else if (cfg_we) begin
      ws       <= ws_cfg;
      lowest   <= 32'd1;
      next_seq <= 32'd1;
      top      <= 32'(ws_cfg);
      span     <= '0;
      low_slot <= '0;
      valid    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            case (item.op)
              OP_STORE: begin
                is_store <= 1'b1;
                if (store_ok) state <= S_ACT;
              end
              OP_FETCH, OP_FETCH_LOW: begin
                is_store <= 1'b0;
                if (fetch_ok) state <= S_ACT;
              end
              OP_SLIDE_CNT: begin
                cnt   <= CW'(item.count);
                state <= S_SLIDE;
              end
              OP_SLIDE_TO: begin
                cnt <= CW'(off_full[SW-1:0]);
                if (slide_to_ok) state <= S_SLIDE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ACT: begin
          if (is_store) begin
            if (!slot_busy) begin
              valid[slot] <= 1'b1;
              if (raise_next) begin
                next_seq <= seq_r + 32'd1;
                span     <= span_store;
              end
            end
            state <= S_IDLE;
          end else begin
            state <= slot_busy ? S_READ : S_IDLE;
          end
        end
        S_READ: state <= S_IDLE;
        S_SLIDE: begin
          if ((cnt == '0) || (span == '0)) begin
            state <= S_IDLE;
          end else begin
            // one step: drop the lowest slot and advance the window
            valid[low_slot] <= 1'b0;
            low_slot        <= (low_slot == ws) ? '0 : (low_slot + SW'(1));
            lowest          <= lowest + 32'd1;
            top             <= top + 32'd1;
            span            <= span - SW'(1);
            cnt             <= cnt - CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand latches
  always_ff @(posedge clk) begin
    if (item_take) begin
      seq_r  <= item.seq;
      size_r <= item.size;
      ref_r  <= REF_WIDTH'(item.pref[KW-1:0]);
      off_r  <= off_full[SW-1:0];
    end
  end

  // slot memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[slot] <= {size_r, ref_r};
    if (mem_re) rd_data <= mem[slot];
  end

endmodule

`default_nettype wire

>>> rtl/swpb_outq.sv
// result queue: two-entry fifo between exec and the result ports
// depends on swpb_pkg
`default_nettype none

module swpb_outq import swpb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res_in,
  output logic    res_room,
  output logic    empty,
  input  logic    pop,
  output result_t res_out
);

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       put;
  logic       take;

  assign res_room = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = q[rd_ptr];
  assign put      = res_push && res_room;
  assign take     = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (put) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      if (put && !take) begin
        count <= count + 2'd1;
      end else if (!put && take) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put) q[wr_ptr] <= res_in;
  end

endmodule

`default_nettype wire

>>> rtl/sliding_window_packet_buffer.sv
// top level of the sliding window packet buffer
// depends on swpb_pkg, swpb_front, swpb_exec, swpb_outq
`default_nettype none

// Selective-repeat window store with queue-style ports on both sides. Command
// words enter through push/full into a two-deep command queue, the exec unit
// runs them one at a time against the window state and a ring of
// window_size+1 slots, and each command yields exactly one result word through
// a two-deep result queue read with empty/pop. A store is range-checked in the
// idle state and answered from the slot access state; a fetch likewise, a hit
// only after the registered slot memory read; out-of-range and unknown commands
// end at the range check; slides clear one slot per cycle, then answer. The exec
// sequencer and its single memory port set this order. Slot occupancy lives in
// flip-flops cleared by reset, so there is no clearing pass. A window_size
// write (saturated to 1..MAX_WINDOW) is registered and empties the window; it
// must only be issued while the block is idle.
module sliding_window_packet_buffer import swpb_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int REF_WIDTH  = REF_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SEQ_W-1:0]    seq_num,
  input  logic [PREF_W-1:0]   payload_ref,
  input  logic [SIZE_W-1:0]   payload_size,
  input  logic [COUNT_W-1:0]  slide_count,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status,
  output logic [SIZE_W-1:0]   found_size,
  output logic [PREF_W-1:0]   found_ref,
  output logic                window_closed,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    window_size
);

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_room;
  logic    res_push;
  result_t res;
  result_t res_out;

  // classify and buffer incoming words
  swpb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .seq_num      (seq_num),
    .payload_ref  (payload_ref),
    .payload_size (payload_size),
    .slide_count  (slide_count),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  // window state, slot memory and sequencer
  swpb_exec #(
    .MAX_WINDOW (MAX_WINDOW),
    .REF_WIDTH  (REF_WIDTH)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .window_size (window_size),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .res_room    (res_room),
    .res_push    (res_push),
    .res         (res)
  );

  // result words wait here until popped
  swpb_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign status        = res_out.status;
  assign found_size    = res_out.found_size;
  assign found_ref     = res_out.found_ref;
  assign window_closed = res_out.window_closed;

endmodule

`default_nettype wire

>>> rtl/swpb_checker.sv
// port-level checker for the sliding window packet buffer, bound to the top
// depends on swpb_pkg and sliding_window_packet_buffer_defines.svh
`default_nettype none

`include "sliding_window_packet_buffer_defines.svh"

module swpb_checker import swpb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [STATUS_W-1:0] status,
  input logic [SIZE_W-1:0]   found_size,
  input logic [PREF_W-1:0]   found_ref,
  input logic                window_closed
);

  // a stalled result word stays put
  `SWPB_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status) && $stable(found_size) && $stable(found_ref) && $stable(window_closed), "result word changed while stalled")

  // fetched data only accompanies a good status
  `SWPB_ASSERT_IMPL(a_zero, !empty && (status != ST_OK), (found_size == '0) && (found_ref == '0), "nonzero fetch data on a failed result")

  // both queues come out of reset empty
  `SWPB_ASSERT_IMPL(a_reset, $past(rst), empty && !full, "queues not empty after reset")

endmodule

bind sliding_window_packet_buffer swpb_checker u_swpb_checker (.*);

`default_nettype wire
